### hw/rtl/numlit_pkg.sv
// numlit_pkg: types, codes and character constants for the numeric literal parser
// shared by numlit_step, numlit_fmt, numeric_literal_parser_unit and the bench; no dependencies
package numlit_pkg;

   // configuration register
   localparam int unsigned WIDTH_BITS = 6;
   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 6'd32;
   localparam int unsigned VALUE_BITS = 32;

   // ascii codes that steer the parse
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   // parse mode, one-hot
   typedef enum logic [3:0] {
      MODE_UNDECIDED = 4'b0001,
      MODE_ZERO      = 4'b0010,
      MODE_HEX       = 4'b0100,
      MODE_DEC       = 4'b1000
   } mode_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_BAD_HEX = 2'd2,
      STATUS_BAD_DEC = 2'd3
   } status_type;

   // one request: a character of the literal
   typedef struct packed {
      logic [7:0] character;
      logic       is_last;
      logic       no_char;
   } req_type;

   // one response
   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      status_type            status;
   } rsp_type;

   // running parse state
   typedef struct packed {
      logic [1:0]            char_position;
      mode_type              mode;
      logic                  is_negative;
      logic [VALUE_BITS-1:0] accumulator;
      logic                  bad_char_seen;
   } state_type;

   localparam state_type STATE_RESET = '{
      char_position: 2'd0,
      mode:          MODE_UNDECIDED,
      is_negative:   1'b0,
      accumulator:   '0,
      bad_char_seen: 1'b0
   };

   // judged literal, before negation and masking
   typedef struct packed {
      logic [VALUE_BITS-1:0] accumulator;
      logic                  is_negative;
      logic                  is_hex;
      status_type            status;
   } raw_type;

endpackage

### hw/rtl/numlit_step.sv
// numlit_step: per-character next-state logic and end-of-literal judgement
// depends on numlit_pkg
module numlit_step (
   input  numlit_pkg::req_type   req,
   input  numlit_pkg::state_type state,
   output numlit_pkg::state_type state_next,
   output logic                  ends,
   output numlit_pkg::raw_type   raw
);

   numlit_pkg::state_type upd;
   logic [7:0] c;
   logic is_digit;
   logic is_hex_digit;
   logic [3:0] hex_digit;
   logic do_dec;
   logic dec_first;
   logic [numlit_pkg::VALUE_BITS-1:0] dec_acc;
   logic [numlit_pkg::VALUE_BITS-1:0] hex_acc;

   assign c = req.character;
   assign ends = req.no_char | req.is_last;

   // digit classification
   always_comb begin
      is_digit = c inside {[numlit_pkg::CHAR_ZERO:numlit_pkg::CHAR_NINE]};
      is_hex_digit = 1'b1;
      hex_digit = 4'd0;
      if (is_digit) begin
         hex_digit = 4'(c - numlit_pkg::CHAR_ZERO);
      end else if (c inside {[numlit_pkg::CHAR_LOWER_A:numlit_pkg::CHAR_LOWER_F]}) begin
         hex_digit = 4'(c - numlit_pkg::CHAR_LOWER_A + 8'd10);
      end else if (c inside {[numlit_pkg::CHAR_UPPER_A:numlit_pkg::CHAR_UPPER_F]}) begin
         hex_digit = 4'(c - numlit_pkg::CHAR_UPPER_A + 8'd10);
      end else begin
         is_hex_digit = 1'b0;
      end
   end

   // times ten plus digit, and shift in a nibble
   assign dec_acc = (state.accumulator << 3) + (state.accumulator << 1)
                  + {24'd0, 4'd0, hex_digit};
   assign hex_acc = {state.accumulator[numlit_pkg::VALUE_BITS-5:0], hex_digit};

   // take one character
   always_comb begin
      upd = state;
      do_dec = 1'b0;
      dec_first = 1'b0;
      if (!req.no_char) begin
         case (state.mode)
            numlit_pkg::MODE_UNDECIDED: begin
               if (c == numlit_pkg::CHAR_ZERO) begin
                  upd.mode = numlit_pkg::MODE_ZERO;
               end else begin
                  upd.mode = numlit_pkg::MODE_DEC;
                  do_dec = 1'b1;
                  dec_first = 1'b1;
               end
            end
            numlit_pkg::MODE_ZERO: begin
               if (c == numlit_pkg::CHAR_X) begin
                  upd.mode = numlit_pkg::MODE_HEX;
               end else begin
                  upd.mode = numlit_pkg::MODE_DEC;
                  do_dec = 1'b1;
               end
            end
            numlit_pkg::MODE_HEX: begin
               if (is_hex_digit) begin
                  upd.accumulator = hex_acc;
               end else begin
                  upd.bad_char_seen = 1'b1;
               end
            end
            numlit_pkg::MODE_DEC: begin
               do_dec = 1'b1;
            end
            default: begin
               upd.mode = state.mode;
            end
         endcase
         // decimal character: digit, leading sign, or illegal
         if (do_dec) begin
            if (is_digit) begin
               upd.accumulator = dec_acc;
            end else if (dec_first && c == numlit_pkg::CHAR_MINUS) begin
               upd.is_negative = 1'b1;
            end else if (!(dec_first && c == numlit_pkg::CHAR_PLUS)) begin
               upd.bad_char_seen = 1'b1;
            end
         end
         if (state.char_position != 2'd3) begin
            upd.char_position = state.char_position + 2'd1;
         end
      end
   end

   // judge the literal and clear the state at its end
   always_comb begin
      raw.accumulator = upd.accumulator;
      raw.is_negative = upd.is_negative;
      raw.is_hex = (upd.mode == numlit_pkg::MODE_HEX);
      if (upd.char_position == 2'd0) begin
         raw.status = numlit_pkg::STATUS_EMPTY;
      end else if (raw.is_hex && upd.char_position == 2'd3) begin
         raw.status = upd.bad_char_seen ? numlit_pkg::STATUS_BAD_HEX : numlit_pkg::STATUS_OK;
      end else if (raw.is_hex || upd.bad_char_seen) begin
         raw.status = numlit_pkg::STATUS_BAD_DEC;
      end else begin
         raw.status = numlit_pkg::STATUS_OK;
      end
      state_next = ends ? numlit_pkg::STATE_RESET : upd;
   end

endmodule

### hw/rtl/numlit_fmt.sv
// numlit_fmt: sign and width fitting of a judged literal into the response
// depends on numlit_pkg
module numlit_fmt (
   input  numlit_pkg::raw_type                    raw,
   input  logic [numlit_pkg::WIDTH_BITS-1:0]      width,
   output numlit_pkg::rsp_type                    rsp
);

   logic [numlit_pkg::WIDTH_BITS-1:0] dec_bits;
   logic [numlit_pkg::WIDTH_BITS-1:0] hex_bits;
   logic [numlit_pkg::WIDTH_BITS-1:0] keep_bits;
   logic [numlit_pkg::VALUE_BITS-1:0] mask;
   logic [numlit_pkg::VALUE_BITS-1:0] signed_acc;

   // widths above 32 act as 32; hex rounds up to whole nibbles
   assign dec_bits = (width > 6'd32) ? 6'd32 : width;
   assign hex_bits = (dec_bits + 6'd3) & ~6'd3;
   assign keep_bits = raw.is_hex ? hex_bits : dec_bits;

   // low mask of keep_bits ones
   always_comb begin
      if (keep_bits[5]) begin
         mask = '1;
      end else begin
         mask = ~({numlit_pkg::VALUE_BITS{1'b1}} << keep_bits[4:0]);
      end
   end

   assign signed_acc = raw.is_negative ? (32'd0 - raw.accumulator) : raw.accumulator;

   // error results carry zero
   always_comb begin
      rsp.status = raw.status;
      if (raw.status == numlit_pkg::STATUS_OK) begin
         rsp.value = signed_acc & mask;
      end else begin
         rsp.value = '0;
      end
   end

endmodule

### hw/rtl/numeric_literal_parser_unit.sv
// numeric_literal_parser_unit: top level of the hex/decimal numeric literal parser
// depends on numlit_pkg, numlit_step and numlit_fmt
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   numlit_pkg::req_type (one character)
//   rsp_      out        rsp_valid/rsp_stall   numlit_pkg::rsp_type (value, status)
//   csr_      in         csr_write             csr_data (width, 6 bits)
//
// one character is taken per cycle while req_stall is low; a request waits in the input
// register, then the step logic folds it into the parse state in one pass
// the response appears in the cycle after the last character is processed
// reset is synchronous and clears the pipeline, parse state and width (32)
// a stalled response holds back only the request that ends the next literal
module numeric_literal_parser_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  numlit_pkg::req_type               req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output numlit_pkg::rsp_type               rsp_payload,
   input  logic                              csr_write,
   input  logic [numlit_pkg::WIDTH_BITS-1:0] csr_data
);

   logic                              in_valid_ff;
   logic                              in_valid_in;
   numlit_pkg::req_type               in_req_ff;
   numlit_pkg::state_type             state_ff;
   numlit_pkg::state_type             state_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   numlit_pkg::raw_type               raw_ff;
   numlit_pkg::raw_type               raw_in;
   logic [numlit_pkg::WIDTH_BITS-1:0] width_ff;
   logic                              step_ends;
   logic                              out_free;
   logic                              advance;
   logic                              accept;

   // per-character logic
   numlit_step u_step (
      .req        (in_req_ff),
      .state      (state_ff),
      .state_next (state_in),
      .ends       (step_ends),
      .raw        (raw_in)
   );

   // handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!step_ends || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && step_ends) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= numlit_pkg::STATE_RESET;
         width_ff     <= numlit_pkg::WIDTH_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_write) begin
            width_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_req_ff <= req_payload;
      end
      if (advance && step_ends) begin
         raw_ff <= raw_in;
      end
   end

   // sign and width fitting of the held response
   numlit_fmt u_fmt (
      .raw   (raw_ff),
      .width (width_ff),
      .rsp   (rsp_payload)
   );

   assign rsp_valid = rsp_valid_ff;

   // checks
   a_end_waits_for_rsp: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && step_ends && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("literal end processed while response still held");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(advance && step_ends) |->
         state_ff.char_position == 2'd0 && state_ff.mode == numlit_pkg::MODE_UNDECIDED)
      else $error("parse state not cleared after literal end");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload.status != numlit_pkg::STATUS_OK |-> rsp_payload.value == '0)
      else $error("error response carries a non-zero value");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("request stalled without a pending item and response");

endmodule

### verif/tb_numeric_literal_parser_unit.sv
// tb_numeric_literal_parser_unit: self-checking bench for the numeric literal parser
// drives literals one character per request, predicts each result and checks it
// depends on numlit_pkg and numeric_literal_parser_unit
module tb_numeric_literal_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import numlit_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_write = 1'b0;
   logic [WIDTH_BITS-1:0] csr_data = WIDTH_RESET;

   // characters waiting to be offered, and parse results still owed by the block
   req_type pending_chars[$];
   rsp_type results_due[$];
   logic    req_taken = 1'b0;
   int      send_idle_pct = 14;
   int      recv_idle_pct = 45;
   int      mismatches = 0;
   int      phase_items;

   // model of the parse state and the width register
   logic [WIDTH_BITS-1:0] model_width;
   logic [1:0]            lit_count;
   mode_type              lit_mode;
   logic                  lit_negative;
   logic [VALUE_BITS-1:0] lit_value;
   logic                  lit_bad;

   numeric_literal_parser_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_data    (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #3000000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   // ---------------------------------------------------------------- prediction

   function automatic logic [31:0] low_bits(input int n);
      if (n >= 32) return '1;
      return (32'd1 << n) - 32'd1;
   endfunction

   // bit 4 flags a legal hex digit, bits 3:0 carry its value
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return {1'b1, 4'(c - CHAR_ZERO)};
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) return {1'b1, 4'(c - CHAR_LOWER_A + 8'd10)};
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) return {1'b1, 4'(c - CHAR_UPPER_A + 8'd10)};
      return 5'b0;
   endfunction

   function automatic void clear_literal();
      lit_count = 2'd0;
      lit_mode = MODE_UNDECIDED;
      lit_negative = 1'b0;
      lit_value = '0;
      lit_bad = 1'b0;
   endfunction

   function automatic void decimal_char(input logic [7:0] c, input logic first);
      if (c >= CHAR_ZERO && c <= CHAR_NINE)
         lit_value = lit_value * 32'd10 + 32'(c - CHAR_ZERO);
      else if (first && c == CHAR_MINUS)
         lit_negative = 1'b1;
      else if (!(first && c == CHAR_PLUS))
         lit_bad = 1'b1;
   endfunction

   function automatic void parse_char(input logic [7:0] c);
      logic [4:0] nib;
      case (lit_mode)
         MODE_UNDECIDED: begin
            if (c == CHAR_ZERO) begin
               lit_mode = MODE_ZERO;
            end else begin
               lit_mode = MODE_DEC;
               decimal_char(c, 1'b1);
            end
         end
         MODE_ZERO: begin
            if (c == CHAR_X) begin
               lit_mode = MODE_HEX;
            end else begin
               lit_mode = MODE_DEC;
               decimal_char(c, 1'b0);
            end
         end
         MODE_HEX: begin
            nib = hex_nibble(c);
            if (!nib[4]) lit_bad = 1'b1;
            else lit_value = {lit_value[27:0], nib[3:0]};
         end
         default: decimal_char(c, 1'b0);
      endcase
      if (lit_count != 2'd3) lit_count = lit_count + 2'd1;
   endfunction

   // fold one accepted request in; a literal that ends owes one result
   function automatic void fold_request(input req_type r);
      int      w;
      rsp_type res;
      if (!r.no_char) parse_char(r.character);
      if (!r.no_char && !r.is_last) return;
      w = (model_width > 6'd32) ? 32 : int'(model_width);
      res.value = '0;
      res.status = STATUS_OK;
      if (lit_count == 2'd0)
         res.status = STATUS_EMPTY;
      else if (lit_mode == MODE_HEX && lit_count == 2'd3) begin
         if (lit_bad) res.status = STATUS_BAD_HEX;
         else res.value = lit_value & low_bits(((w + 3) / 4) * 4);
      end else if (lit_mode == MODE_HEX || lit_bad)
         res.status = STATUS_BAD_DEC;
      else
         res.value = (lit_negative ? (32'd0 - lit_value) : lit_value) & low_bits(w);
      results_due.push_back(res);
      clear_literal();
   endfunction

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
         model_width = WIDTH_RESET;
         clear_literal();
      end else begin
         req_taken <= req_valid && !req_stall;
         if (csr_write) model_width = csr_data;
         if (req_valid && !req_stall) fold_request(req_payload);
         // compare a delivered result with the oldest one owed
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               report_mismatch("result with none owed", rsp_payload.value, '0);
            end else begin
               want = results_due.pop_front();
               if (rsp_payload.value !== want.value)
                  report_mismatch("value", rsp_payload.value, want.value);
               if (rsp_payload.status !== want.status)
                  report_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
            end
         end
      end
   end

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_taken) void'(pending_chars.pop_front());
         // a stalled request stays put; otherwise offer the next one or idle
         if (req_valid && !req_taken) begin
         end else if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= pending_chars[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus a long hold-off now and then so the block backs up
   always @(negedge clock) begin : receiver
      int cycles;
      cycles++;
      if ((cycles % 2500) >= 1200 && (cycles % 2500) < 1320)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_char(input logic [7:0] c, input logic last, input logic none);
      req_type r;
      r.character = c;
      r.is_last = last;
      r.no_char = none;
      pending_chars.push_back(r);
      phase_items++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_char(s[i], i == s.len() - 1, 1'b0);
   endtask

   function automatic logic [7:0] random_hex_char();
      int v;
      v = $urandom_range(15);
      if (v < 10) return CHAR_ZERO + 8'(v);
      return ($urandom_range(1) ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(v - 10);
   endfunction

   function automatic logic [7:0] random_noise_char();
      case ($urandom_range(7))
         0: return CHAR_ZERO;
         1: return CHAR_X;
         2: return CHAR_PLUS;
         3: return CHAR_MINUS;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // mostly well-formed hex and decimal literals, some broken ones and noise
   task automatic queue_random_literal();
      logic [7:0] text[$];
      int         kind;
      int         n;
      logic       open_end;
      kind = $urandom_range(99);
      open_end = ($urandom_range(99) < 6);
      if (kind < 40) begin
         text.push_back(CHAR_ZERO);
         text.push_back(CHAR_X);
         n = ($urandom_range(9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
         repeat (n) text.push_back(random_hex_char());
      end else if (kind < 80) begin
         case ($urandom_range(3))
            0: text.push_back(CHAR_MINUS);
            1: text.push_back(CHAR_PLUS);
            default: ;
         endcase
         n = ($urandom_range(7) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 6);
         repeat (n) text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      end else if (kind < 95) begin
         n = $urandom_range(1, 4);
         repeat (n) text.push_back(random_noise_char());
      end
      // corrupt one character now and then
      if (text.size() != 0 && $urandom_range(9) == 0)
         text[$urandom_range(text.size() - 1)] = random_noise_char();
      for (int i = 0; i < text.size(); i++)
         push_char(text[i], !open_end && i == text.size() - 1, 1'b0);
      if (open_end || text.size() == 0)
         push_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
   endtask

   task automatic wait_quiet();
      while (pending_chars.size() != 0 || req_valid || results_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_width(input logic [WIDTH_BITS-1:0] w);
      @(negedge clock);
      csr_data <= w;
      csr_write <= 1'b1;
      @(negedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      logic [WIDTH_BITS-1:0] widths[9];
      widths = '{WIDTH_RESET, 6'd1, 6'd0, 6'd63, 6'd4, 6'd5, 6'd31, 6'd32, 6'd17};
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty, hex ok and bad, bare prefix, signs, leading zero, nul, open end
      phase_items = 0;
      push_char(8'hFF, 1'b0, 1'b1);
      push_text("0x1F");
      push_text("0xg");
      push_text("0x");
      push_text("-");
      push_text("+7");
      push_text("0");
      push_text("09");
      push_char(8'h00, 1'b1, 1'b0);
      push_char(8'hFF, 1'b1, 1'b0);
      push_char(CHAR_ZERO + 8'd1, 1'b0, 1'b0);
      push_char(8'h00, 1'b0, 1'b1);
      push_text("-5");
      push_text("0XF");

      for (int p = 0; p < 9; p++) begin
         if (p != 0) begin
            wait_quiet();
            write_width(p == 8 ? 6'($urandom_range(1, 32)) : widths[p]);
         end
         send_idle_pct = (p < 3) ? 14 : (p < 6) ? 45 : 0;
         recv_idle_pct = (p < 3) ? 45 : (p < 6) ? 14 : 0;
         if (p != 0) phase_items = 0;
         while (phase_items < 180) queue_random_literal();
      end

      wait_quiet();
      repeat (20) @(posedge clock);
      if (results_due.size() != 0)
         report_mismatch("results never delivered", results_due.size(), 0);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
hw/rtl/numlit_pkg.sv
hw/rtl/numlit_step.sv
hw/rtl/numlit_fmt.sv
hw/rtl/numeric_literal_parser_unit.sv
verif/tb_numeric_literal_parser_unit.sv
